FILE: hdl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for the decimal text converter
// Holds the ASCII codes, the BCD cell control bundle and the FSM states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

    localparam int          DIGIT_BITS  = 4;
    localparam logic [7:0]  ASCII_ZERO  = 8'h30;
    localparam logic [7:0]  ASCII_MINUS = 8'h2D;

    // control broadcast to every BCD cell
    typedef struct packed {
        logic clr;      // load zero
        logic bit_sh;   // add-3 correct then shift in one binary bit
        logic dig_sh;   // move a whole digit one place up the chain
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/sitda_cell.sv
// ----------------------------------------------------------------------------
// sitda_cell: one BCD digit of the shift-and-add-3 chain
// Holds a decimal digit; shifts binary bits in from below during conversion
// and passes whole digits upward while the text is read out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitda_cell
    import sitda_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic                  i_bit,
    input  wire logic [DIGIT_BITS-1:0] i_digit,
    output logic [DIGIT_BITS-1:0]      o_digit,
    output logic                       o_carry
);

    logic [DIGIT_BITS-1:0] r_digit;
    logic [DIGIT_BITS-1:0] n_digit;
    logic [DIGIT_BITS-1:0] w_adj;

    // add 3 when the digit would overflow past 9 after doubling
    assign w_adj   = (r_digit >= DIGIT_BITS'(5)) ? r_digit + DIGIT_BITS'(3) : r_digit;
    assign o_carry = w_adj[DIGIT_BITS-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clr) begin
            n_digit = '0;
        end else if (i_ctl.bit_sh) begin
            n_digit = {w_adj[DIGIT_BITS-2:0], i_bit};
        end else if (i_ctl.dig_sh) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

`default_nettype wire

FILE: hdl/signed_int_to_decimal_ascii_core.sv
// From the input transaction to the first character: VALUE_BITS shift steps, then Z
// leading zeros dropped plus one skip check, then the output register is loaded.
// After that, one character per cycle while the receiver is ready, with the sign first.
// Z is at most NDIG-1. The block takes one number at a time: it is ready again only
// once the last character of the previous number has been loaded for output.
// Reset (synchronous, active low) returns the controller to idle and empties
// the output register; the digit cells carry no reset.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed integer to decimal ASCII text
// Converts the magnitude with a chain of BCD cells and streams '-' when negative and
// the digits most significant first, flagging the final character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_core
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_char_code,
    output logic                       o_last
);

    // digits needed for 2^(VALUE_BITS-1)
    localparam int NDIG   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCNT_W = $clog2(VALUE_BITS + 1);
    localparam int RCNT_W = $clog2(NDIG + 1);

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_sign_pend, n_sign_pend;
    logic [BCNT_W-1:0]     r_bit_cnt, n_bit_cnt;
    logic [RCNT_W-1:0]     r_rem, n_rem;
    logic                  r_o_valid, n_o_valid;
    logic [7:0]            r_char, n_char;
    logic                  r_last, n_last;

    t_cell_ctl             w_ctl;
    logic [DIGIT_BITS-1:0] w_dig [NDIG];
    logic [NDIG-1:0]       w_carry;
    logic [DIGIT_BITS-1:0] w_top;
    logic                  w_slot;

    assign w_top   = w_dig[NDIG-1];
    assign w_slot  = !r_o_valid || i_ready;
    assign o_ready = (r_state == S_IDLE);

    // BCD cell chain, cell 0 least significant
    for (genvar k = 0; k < NDIG; k++) begin : g_cell
        if (k == 0) begin : g_lsd
            sitda_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_bit   (r_mag[VALUE_BITS-1]),
                .i_digit ('0),
                .o_digit (w_dig[k]),
                .o_carry (w_carry[k])
            );
        end else begin : g_upper
            sitda_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_bit   (w_carry[k-1]),
                .i_digit (w_dig[k-1]),
                .o_digit (w_dig[k]),
                .o_carry (w_carry[k])
            );
        end
    end

    // controller: next state, chain control and output register load
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_sign_pend = r_sign_pend;
        n_bit_cnt   = r_bit_cnt;
        n_rem       = r_rem;
        n_o_valid   = r_o_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        w_ctl       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sign_pend = i_value[VALUE_BITS-1];
                    n_mag       = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                    n_bit_cnt   = BCNT_W'(VALUE_BITS);
                    n_rem       = RCNT_W'(NDIG);
                    w_ctl.clr   = 1'b1;
                    n_state     = S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.bit_sh = 1'b1;
                n_mag        = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bit_cnt    = r_bit_cnt - 1'b1;
                if (r_bit_cnt == BCNT_W'(1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if (w_top == '0 && r_rem > RCNT_W'(1)) begin
                    w_ctl.dig_sh = 1'b1;
                    n_rem        = r_rem - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_o_valid = 1'b1;
                    if (r_sign_pend) begin
                        n_char      = ASCII_MINUS;
                        n_last      = 1'b0;
                        n_sign_pend = 1'b0;
                    end else begin
                        n_char       = ASCII_ZERO + {4'd0, w_top};
                        n_last       = (r_rem == RCNT_W'(1));
                        w_ctl.dig_sh = 1'b1;
                        n_rem        = r_rem - 1'b1;
                        if (r_rem == RCNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_sign_pend <= n_sign_pend;
        r_bit_cnt   <= n_bit_cnt;
        r_rem       <= n_rem;
        r_char      <= n_char;
        r_last      <= n_last;
    end

    assign o_valid     = r_o_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

`default_nettype wire

FILE: sim/tb_signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core: self-checking bench for the converter
// Feeds signed 32-bit numbers through a valid/ready driver, predicts the
// decimal ASCII text of each accepted number and checks every character and
// last flag leaving the block, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_core;

    import sitda_pkg::*;

    localparam int VALUE_BITS  = 32;
    localparam int RADIX       = 10;
    localparam int RANDOM_NUMS = 360;
    localparam int DRAIN_CYCLES = 80;   // conversion, zero skip and text burst

    // one number waiting to be offered to the block
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        bit                    drain_first;
        bit                    calm;
    } t_number;

    // one predicted character of output text
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_text_char;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [7:0]            o_char_code;
    logic                  o_last;

    t_number    pending_numbers[$];
    t_text_char decimal_text[$];

    int unsigned numbers_offered = 0;
    int unsigned numbers_taken   = 0;
    int unsigned negatives_taken = 0;
    int unsigned chars_taken     = 0;
    int unsigned send_gap        = 0;
    int unsigned hold_ready      = 0;
    bit          calm_run        = 1'b0;
    bit          failed          = 1'b0;

    signed_int_to_decimal_ascii_core #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always #1 i_clk = ~i_clk;

    // idle length for the next transaction; none at all during a calm run
    function automatic int unsigned draw_idle();
        return calm_run ? 0 : $urandom_range(0, 9);
    endfunction

    // decimal text of one number: optional minus, then digits msd first
    function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] num);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits[$];
        t_text_char            ch;
        mag = num[VALUE_BITS-1] ? (~num + 1'b1) : num;
        do begin
            digits.push_front(4'(mag % RADIX));
            mag = mag / RADIX;
        end while (mag != 0);
        if (num[VALUE_BITS-1]) begin
            ch.code = ASCII_MINUS;
            ch.last = 1'b0;
            decimal_text.push_back(ch);
        end
        foreach (digits[k]) begin
            ch.code = ASCII_ZERO + 8'(digits[k]);
            ch.last = (k == digits.size() - 1);
            decimal_text.push_back(ch);
        end
    endfunction

    task automatic add_number(input logic [VALUE_BITS-1:0] num, input bit drain,
                              input bit calm);
        t_number item;
        item.value       = num;
        item.drain_first = drain;
        item.calm        = calm;
        pending_numbers.push_back(item);
    endtask

    // number driver: offers the next queued number after a random gap
    always @(negedge i_clk) begin
        logic    next_valid;
        t_number item;
        next_valid = i_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_valid && numbers_taken == numbers_offered) begin
                next_valid = 1'b0;
                send_gap   = draw_idle();
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_numbers.size() > 0) begin
                    // a number marked drain_first waits until all outstanding text has drained
                    if (!pending_numbers[0].drain_first || decimal_text.size() == 0) begin
                        item = pending_numbers.pop_front();
                        calm_run = item.calm;
                        i_value <= item.value;
                        next_valid = 1'b1;
                        numbers_offered++;
                    end
                end
            end
        end
        i_valid <= next_valid;
    end

    // text receiver: drops ready for a random stall after each character
    always @(negedge i_clk) begin
        if (hold_ready > 0) begin
            hold_ready--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor: predict on number acceptance, check each character taken
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                queue_decimal_text(i_value);
                numbers_taken++;
                if (i_value[VALUE_BITS-1])
                    negatives_taken++;
            end
            if (o_valid && i_ready) begin
                chars_taken++;
                hold_ready = draw_idle();
                if (decimal_text.size() == 0) begin
                    $error("unexpected character transaction: char_code 0x%02h last %0b",
                           o_char_code, o_last);
                    failed = 1'b1;
                end else begin
                    want = decimal_text.pop_front();
                    if (o_char_code !== want.code) begin
                        $error("char_code mismatch: expected 0x%02h, got 0x%02h",
                               want.code, o_char_code);
                        failed = 1'b1;
                    end
                    if (o_last !== want.last) begin
                        $error("last mismatch: expected %0b, got %0b", want.last, o_last);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [VALUE_BITS-1:0] num;
        longint                span_lo;
        longint                span_hi;
        int                    ndig;
        bit                    calm_blk;

        // directed: zero, edges of the range, digit count boundaries
        add_number(32'd0, 1'b0, 1'b0);
        add_number(32'd1, 1'b0, 1'b0);
        add_number(-32'sd1, 1'b0, 1'b0);
        add_number(32'd9, 1'b0, 1'b0);
        add_number(32'd10, 1'b0, 1'b0);
        add_number(-32'sd10, 1'b0, 1'b0);
        add_number(32'd99, 1'b0, 1'b0);
        add_number(32'd100, 1'b0, 1'b0);
        add_number(-32'sd7, 1'b0, 1'b0);
        add_number(32'h7FFF_FFFF, 1'b0, 1'b0);
        add_number(32'h8000_0000, 1'b0, 1'b0);
        add_number(32'h8000_0001, 1'b0, 1'b0);
        add_number(32'd999_999_999, 1'b0, 1'b0);
        add_number(32'd1_000_000_000, 1'b0, 1'b0);
        add_number(-32'sd999_999_999, 1'b0, 1'b0);
        add_number(-32'sd1_000_000_000, 1'b0, 1'b0);
        add_number(32'd1_234_567_890, 1'b0, 1'b1);
        add_number(-32'sd1_234_567_890, 1'b0, 1'b1);
        add_number(32'h5555_5555, 1'b0, 1'b1);
        add_number(32'hAAAA_AAAA, 1'b0, 1'b1);
        add_number(32'd1_000_000, 1'b0, 1'b0);
        add_number(32'd100_000_000, 1'b0, 1'b0);

        // random: full words, values of a chosen length, and small values
        calm_blk = 1'b0;
        for (int n = 0; n < RANDOM_NUMS; n++) begin
            if (n % 40 == 0)
                calm_blk = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: num = $urandom();
                3: num = 32'($urandom_range(0, 20)) - 32'd10;
                default: begin
                    ndig = $urandom_range(1, 10);
                    span_lo = 1;
                    repeat (ndig - 1) span_lo = span_lo * RADIX;
                    span_hi = span_lo * RADIX - 1;
                    if (ndig == 1)
                        span_lo = 0;
                    if (span_hi > 64'sd2147483647)
                        span_hi = 64'sd2147483647;
                    num = $urandom_range(32'(span_hi), 32'(span_lo));
                    if ($urandom_range(0, 1))
                        num = ~num + 1'b1;
                end
            endcase
            add_number(num, (n == 0) || ($urandom_range(0, 39) == 0), calm_blk);
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || i_valid || decimal_text.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (decimal_text.size() != 0) begin
            $error("%0d predicted characters never arrived", decimal_text.size());
            failed = 1'b1;
        end
        $display("tb: %0d numbers converted (%0d negative), %0d characters checked",
                 numbers_taken, negatives_taken, chars_taken);
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
